FILE: rtl/core/trb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, constants and tables for the range and bearing block.
// ----------------------------------------------------------------------------
package trb_pkg;

	localparam int COORD_W           = 20;
	localparam int DIFF_W            = 21;
	localparam int DIST_W            = 21;
	localparam int BEAR_W            = 15;
	localparam int GUARD_BITS        = 8;
	localparam int ANG_FRAC          = 16;
	localparam int XW                = 32;
	localparam int ZW                = 32;
	localparam int GAIN_W            = 30;
	localparam int GAIN_FRAC         = 30;
	localparam int TABLE_LEN         = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int COORD_FRAC_BITS   = 8;

	localparam logic signed [ZW-1:0] DEG90  = 32'sd377487360;
	localparam logic signed [ZW-1:0] DEG360 = 32'sd1509949440;
	localparam logic [DIST_W-1:0]    DIST_MAX     = 21'd1482910;
	localparam int                   BEARING_FULL = 23040;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cordic_t;

	// atan(2^-idx) in 1/(64*2^16) degree units
	function automatic logic signed [ZW-1:0] atan_val(input int idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			0:  v = 32'sd188743680;
			1:  v = 32'sd111421900;
			2:  v = 32'sd58872272;
			3:  v = 32'sd29884485;
			4:  v = 32'sd15000234;
			5:  v = 32'sd7507429;
			6:  v = 32'sd3754631;
			7:  v = 32'sd1877430;
			8:  v = 32'sd938729;
			9:  v = 32'sd469366;
			10: v = 32'sd234683;
			11: v = 32'sd117342;
			12: v = 32'sd58671;
			13: v = 32'sd29335;
			14: v = 32'sd14668;
			15: v = 32'sd7334;
			16: v = 32'sd3667;
			17: v = 32'sd1833;
			18: v = 32'sd917;
			19: v = 32'sd458;
			20: v = 32'sd229;
			21: v = 32'sd115;
			22: v = 32'sd57;
			23: v = 32'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

	// inverse cordic gain in Q30 for a given stage count
	function automatic logic [GAIN_W-1:0] gain_q30(input int stages);
		int gi;
		logic [GAIN_W-1:0] g;
		gi = stages - 8;
		if (gi < 0) gi = 0;
		if (gi > 16) gi = 16;
		unique case (gi)
			0: g = 30'd652039507;
			1: g = 30'd652034532;
			2: g = 30'd652033289;
			3: g = 30'd652032978;
			4: g = 30'd652032900;
			5: g = 30'd652032881;
			6: g = 30'd652032876;
			default: g = 30'd652032874;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/trb_pos_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pos_if
// Position pair channel: robot and target coordinates with valid/ready.
// ----------------------------------------------------------------------------
interface trb_pos_if;
	import trb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] robot_x;
	logic signed [COORD_W-1:0] robot_y;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;

	modport source (output valid, robot_x, robot_y, target_x, target_y, input ready);
	modport sink (input valid, robot_x, robot_y, target_x, target_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/trb_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_res_if
// Result channel: distance and bearing with valid/ready.
// ----------------------------------------------------------------------------
interface trb_res_if;
	import trb_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [BEAR_W-1:0] bearing;

	modport source (output valid, distance, bearing, input ready);
	modport sink (input valid, distance, bearing, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/trb_prerot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_prerot
// Offset forming and quadrant pre-rotation ahead of the cordic chain.
// ----------------------------------------------------------------------------
module trb_prerot import trb_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [COORD_W-1:0] robot_x,
	input  wire logic signed [COORD_W-1:0] robot_y,
	input  wire logic signed [COORD_W-1:0] target_x,
	input  wire logic signed [COORD_W-1:0] target_y,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output cordic_t                        out_data
);

	logic                     valid_s1;
	cordic_t                  data_s1;
	cordic_t                  nxt;
	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic signed [XW-1:0]     xg;
	logic signed [XW-1:0]     yg;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		dx = DIFF_W'(target_x) - DIFF_W'(robot_x);
		dy = DIFF_W'(target_y) - DIFF_W'(robot_y);
		xg = XW'(dy) <<< GUARD_BITS;
		yg = XW'(dx) <<< GUARD_BITS;
		nxt.zero = (dx == '0) && (dy == '0);
		// left half plane: turn by 90 degrees so the pass converges
		if (xg < 0) begin
			if (yg >= 0) begin
				nxt.x = yg;
				nxt.y = -xg;
				nxt.z = DEG90;
			end else begin
				nxt.x = -yg;
				nxt.y = xg;
				nxt.z = -DEG90;
			end
		end else begin
			nxt.x = xg;
			nxt.y = yg;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/trb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_cell
// One cordic vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module trb_cell import trb_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire cordic_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output cordic_t      out_data
);

	localparam logic signed [ZW-1:0] ATAN = atan_val(IDX);

	logic                 valid_q;
	cordic_t              data_q;
	cordic_t              nxt;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		xs = in_data.x >>> IDX;
		ys = in_data.y >>> IDX;
		nxt.zero = in_data.zero;
		if (in_data.y >= 0) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ATAN;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/trb_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trb_post
// Gain correction of the length and rounding of the angle to the bearing.
// ----------------------------------------------------------------------------
module trb_post import trb_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire cordic_t      in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [DIST_W-1:0] distance,
	output logic [BEAR_W-1:0] bearing
);

	localparam logic [GAIN_W-1:0] GAIN    = gain_q30(CORDIC_STAGES);
	localparam int                MAG_W   = XW - 1;
	localparam int                PROD_W  = MAG_W + GAIN_W;
	localparam int                D_SHIFT = GAIN_FRAC + GUARD_BITS;
	localparam int                DR_W    = PROD_W - D_SHIFT;
	localparam logic [PROD_W-1:0] D_RND   = PROD_W'(64'd1 << (D_SHIFT - 1));
	localparam int                ZP_W    = ZW + 1;
	localparam logic signed [ZP_W-1:0] B_RND = ZP_W'(64'd1 << (ANG_FRAC - 1));
	localparam int                BR_W    = ZP_W - ANG_FRAC;
	localparam logic [BR_W-1:0]   B_FULL  = BR_W'(BEARING_FULL);

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s2;
	logic [PROD_W-1:0]    prod_s1;
	logic signed [ZW-1:0] z_s1;
	logic                 zero_s1;
	logic [DIST_W-1:0]    dist_s2;
	logic [BEAR_W-1:0]    bear_s2;

	logic [MAG_W-1:0]       mag;
	logic [PROD_W-1:0]      dsum;
	logic [DR_W-1:0]        dround;
	logic [DIST_W-1:0]      dist_nxt;
	logic signed [ZP_W-1:0] zp;
	logic signed [ZP_W-1:0] zr;
	logic [BR_W-1:0]        bw;
	logic [BEAR_W-1:0]      bear_nxt;

	assign ready_s2  = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || ready_s2;
	assign out_valid = valid_s2;
	assign distance  = dist_s2;
	assign bearing   = bear_s2;

	// negative length clamps to zero
	assign mag = in_data.x[XW-1] ? '0 : in_data.x[MAG_W-1:0];

	always_comb begin
		dsum   = prod_s1 + D_RND;
		dround = dsum[PROD_W-1:D_SHIFT];
		if (dround > DR_W'(DIST_MAX)) begin
			dist_nxt = DIST_MAX;
		end else begin
			dist_nxt = dround[DIST_W-1:0];
		end

		zp = ZP_W'(z_s1);
		if (zp < 0) begin
			zp = zp + ZP_W'(DEG360);
		end
		zr = zp + B_RND;
		bw = zr[ZP_W-1:ANG_FRAC];
		if (zp < 0) begin
			bw = '0;
		end
		// full turn wraps to zero
		if (bw >= B_FULL) begin
			bw = bw - B_FULL;
		end
		if (bw >= B_FULL) begin
			bw = '0;
		end
		bear_nxt = bw[BEAR_W-1:0];

		if (zero_s1) begin
			dist_nxt = '0;
			bear_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(GAIN);
			z_s1    <= in_data.z;
			zero_s1 <= in_data.zero;
		end
		if (ready_s2 && valid_s1) begin
			dist_s2 <= dist_nxt;
			bear_s2 <= bear_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/target_range_and_bearing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// target_range_and_bearing
// Distance and clockwise-from-+y bearing from a robot to a target position.
// ----------------------------------------------------------------------------
// The block takes one robot/target position pair per cycle while results
// are taken and returns the straight-line distance (same fixed-point
// format as the inputs) and the bearing in 1/64 degree, 0 to 23039.
// Internally it forms the offsets, pre-rotates left half plane vectors by
// 90 degrees, and runs an unrolled chain of CORDIC_STAGES (at most
// TABLE_LEN) vectoring cells, each with its own register, then a multiply
// stage for gain correction and a rounding stage that feeds the output
// register. The rate is set by the chain of cells, each of which hands its
// item on when the next one can take it. Every stage has its own valid
// bit and takes a new item when it is empty or its successor moves, so
// bubbles close up and empty stages keep filling while a finished result
// waits at the output. A zero offset gives distance 0 and bearing 0.
// ----------------------------------------------------------------------------
module target_range_and_bearing import trb_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	trb_pos_if.sink   pos,
	trb_res_if.source res
);

	// the angle table has TABLE_LEN entries; more stages are not built
	localparam int NCELL = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

	// chain links: link 0 is the pre-rotation output, link NCELL feeds post
	logic    vld [NCELL+1];
	logic    rdy [NCELL+1];
	cordic_t dat [NCELL+1];

	// offsets and quadrant fold
	trb_prerot u_prerot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pos.valid),
		.in_ready (pos.ready),
		.robot_x  (pos.robot_x),
		.robot_y  (pos.robot_y),
		.target_x (pos.target_x),
		.target_y (pos.target_y),
		.out_valid(vld[0]),
		.out_ready(rdy[0]),
		.out_data (dat[0])
	);

	// row of micro-rotation cells, one per stage
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		trb_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[i]),
			.in_ready (rdy[i]),
			.in_data  (dat[i]),
			.out_valid(vld[i+1]),
			.out_ready(rdy[i+1]),
			.out_data (dat[i+1])
		);
	end

	// gain correction, bearing rounding and output register
	trb_post #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[NCELL]),
		.in_ready (rdy[NCELL]),
		.in_data  (dat[NCELL]),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.distance (res.distance),
		.bearing  (res.bearing)
	);

endmodule
`default_nettype wire

FILE: dv/trb_range_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trb_range_checker
// Watches both channels of the range and bearing block and scores its results.
// ----------------------------------------------------------------------------
// Every position pair taken by the block is run through a bit-exact fixed
// point model of the offset, pre-rotation, vectoring pass, gain correction
// and rounding. The answers wait in order and each result that the block
// hands over is compared against the oldest one.
// ----------------------------------------------------------------------------
module trb_range_checker import trb_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	trb_pos_if        pos,
	trb_res_if        res,
	output int        fails,
	output int        pending,
	output int        pairs_seen,
	output int        fixes_seen
);

	localparam int RUN_STAGES = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
	localparam int GAIN_IDX   = (STAGES < 8) ? 0 : ((STAGES > 24) ? 16 : STAGES - 8);
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
		logic [DIST_W-1:0]         dist_exp;
		logic [BEAR_W-1:0]         bear;
	} fix_t;

	// atan(2^-i) in 1/(64*2^16) degree
	longint arctan_step [0:23] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	// inverse vectoring gain, Q30, by stage count 8..24
	longint unsigned inv_gain [0:16] = '{
		652039507, 652034532, 652033289, 652032978, 652032900,
		652032881, 652032876, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874, 652032874, 652032874,
		652032874, 652032874
	};

	fix_t fix_due [$];
	int   n_fail;
	int   n_pairs;
	int   n_fixes;

	function automatic fix_t predict_fix(input logic signed [COORD_W-1:0] rx, ry, tx, ty);
		longint          dx, dy, cx, cy, ang, sx, sy, swap, deg;
		longint unsigned scaled;
		fix_t            f;
		f.rx = rx;
		f.ry = ry;
		f.tx = tx;
		f.ty = ty;
		f.dist_exp = '0;
		f.bear = '0;
		dx = longint'(tx) - longint'(rx);
		dy = longint'(ty) - longint'(ry);
		if (dx == 0 && dy == 0) begin
			return f;
		end
		// vector is (dy, dx) so the angle comes out clockwise from +y
		cx = dy * (64'sd1 <<< GUARD_BITS);
		cy = dx * (64'sd1 <<< GUARD_BITS);
		ang = 0;
		if (cx < 0) begin
			swap = cx;
			if (cy >= 0) begin
				cx = cy;
				cy = -swap;
				ang = longint'(DEG90);
			end else begin
				cx = -cy;
				cy = swap;
				ang = -longint'(DEG90);
			end
		end
		for (int i = 0; i < RUN_STAGES; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (cy >= 0) begin
				cx = cx + sy;
				cy = cy - sx;
				ang = ang + arctan_step[i];
			end else begin
				cx = cx - sy;
				cy = cy + sx;
				ang = ang - arctan_step[i];
			end
		end
		if (cx < 0) cx = 0;
		scaled = cx;
		scaled = (scaled * inv_gain[GAIN_IDX] + (64'd1 << (GAIN_FRAC + GUARD_BITS - 1)))
			>> (GAIN_FRAC + GUARD_BITS);
		if (scaled > DIST_MAX) scaled = DIST_MAX;
		f.dist_exp = scaled[DIST_W-1:0];
		if (ang < 0) ang = ang + longint'(DEG360);
		if (ang < 0) ang = 0;
		deg = (ang + (64'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
		if (deg >= BEARING_FULL) deg = deg - BEARING_FULL;
		if (deg < 0 || deg >= BEARING_FULL) deg = 0;
		f.bear = deg[BEAR_W-1:0];
		return f;
	endfunction

	initial begin
		n_fail = 0;
		n_pairs = 0;
		n_fixes = 0;
	end

	// inputs only move at the rising edge, so the falling edge sees what the
	// next rising edge will take
	always @(negedge clk) begin
		fix_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				n_fixes++;
				if (fix_due.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("unexpected result %0d: distance %0d bearing %0d",
							n_fixes, res.distance, res.bearing);
				end else begin
					want = fix_due.pop_front();
					if (res.distance !== want.dist_exp || res.bearing !== want.bear) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS) begin
							$write("mismatch on result %0d (robot %0d,%0d target %0d,%0d):",
								n_fixes, want.rx, want.ry, want.tx, want.ty);
							$display(" distance exp %0d got %0d, bearing exp %0d got %0d",
								want.dist_exp, res.distance, want.bear, res.bearing);
						end
					end
				end
			end
			if (pos.valid && pos.ready) begin
				n_pairs++;
				fix_due.push_back(predict_fix(pos.robot_x, pos.robot_y,
					pos.target_x, pos.target_y));
			end
		end
		fails <= n_fail;
		pending <= fix_due.size();
		pairs_seen <= n_pairs;
		fixes_seen <= n_fixes;
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the range and bearing block.
// ----------------------------------------------------------------------------
// Drives robot/target position pairs into the block: a directed set of
// corner cases first, then randomized pairs with a mix of far, near, axis,
// diagonal, coincident and extreme offsets. Both channels idle in random
// bursts, the result side holds off once for a long stretch and the input
// side pauses once for a full drain. A separate checker scores the results.
// ----------------------------------------------------------------------------
module tb;
	import trb_pkg::*;

	localparam int ITEMS_TOTAL    = 1450;
	localparam int LATENCY        = CORDIC_STAGES_DEF + 3;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AT        = 500;
	localparam int DRAIN_AT       = 900;
	localparam int CALM_AT        = ITEMS_TOTAL - 150;

	logic clk;
	logic arst_n;

	trb_pos_if pos_ch ();
	trb_res_if res_ch ();

	int fails;
	int pending;
	int pairs_seen;
	int fixes_seen;

	// shared stimulus flags
	bit calm;       // last part of the run: no idling anywhere
	bit hold_req;   // sender asks the result side for the long hold-off
	bit holding;    // result side is in the long hold-off
	int send_rate;  // current idling rate of the sender, 0 means none

	target_range_and_bearing u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos_ch),
		.res    (res_ch)
	);

	trb_range_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pos        (pos_ch),
		.res        (res_ch),
		.fails      (fails),
		.pending    (pending),
		.pairs_seen (pairs_seen),
		.fixes_seen (fixes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one reset at the start, never again
	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// offer one position pair and return on the edge that takes it;
	// called on a rising edge, leaves valid high for the next pair
	task automatic put_pair(input logic signed [COORD_W-1:0] rx, ry, tx, ty);
		int  gap;
		bit  took;
		// random idle burst, never while the result side is being squeezed
		if (!calm && !hold_req && !holding && send_rate != 0
				&& $urandom_range(0, 9) < send_rate) begin
			gap = $urandom_range(1, 12);
			pos_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos_ch.valid <= 1'b1;
		pos_ch.robot_x <= rx;
		pos_ch.robot_y <= ry;
		pos_ch.target_x <= tx;
		pos_ch.target_y <= ty;
		// ready is settled by the falling edge; the next rising edge takes it
		do begin
			@(negedge clk);
			took = pos_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// one of the four extreme coordinate values
	function automatic logic signed [COORD_W-1:0] corner_coord();
		case ($urandom_range(0, 3))
			0: return COORD_W'(-(1 <<< (COORD_W - 1)));
			1: return COORD_W'((1 <<< (COORD_W - 1)) - 1);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// result side: random stall bursts, stretches of none, one long hold-off
	initial begin : result_sink
		int gap;
		int span;
		int rate;
		span = 0;
		rate = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				rate = $urandom_range(0, 3);
				span = $urandom_range(20, 150);
			end
			span--;
			if (hold_req) begin
				// long hold-off so the pipeline fills and stalls its input
				hold_req = 1'b0;
				holding = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ch.ready <= 1'b1;
				holding = 1'b0;
			end else if (!calm && rate != 0 && $urandom_range(0, 9) < rate) begin
				gap = $urandom_range(1, 12);
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: ends the run after too many cycles with no item taken anywhere
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((pos_ch.valid && pos_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles with no item moving, %0d results outstanding",
			WATCHDOG_LIMIT, pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		logic signed [COORD_W-1:0] rx, ry, tx, ty;
		longint                    ox, oy, mag;
		int                        width;
		int                        n_directed;
		int                        n_sent;
		calm = 1'b0;
		hold_req = 1'b0;
		holding = 1'b0;
		send_rate = 0;
		n_sent = 0;
		pos_ch.valid <= 1'b0;
		pos_ch.robot_x <= '0;
		pos_ch.robot_y <= '0;
		pos_ch.target_x <= '0;
		pos_ch.target_y <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// directed part
		send_rate = 3;
		put_pair(0, 0, 0, 0);                                 // zero offset
		put_pair(524287, -524288, 524287, -524288);           // zero offset at extremes
		put_pair(0, 0, 256, 0);                               // due east, 90 degrees
		put_pair(0, 0, 0, 256);                               // due north, 0 degrees
		put_pair(0, 0, 0, -256);                              // due south, 180 degrees
		put_pair(0, 0, -256, 0);                              // due west, 270 degrees
		put_pair(100, 200, 1100, -2800);                      // left half plane, dx >= 0
		put_pair(100, 200, -900, -2800);                      // left half plane, dx < 0
		put_pair(0, 0, -5000, 7);                             // just north of due west
		put_pair(0, 0, -1, 524287);                           // full turn wraps to 0
		put_pair(0, -524288, -1, 524287);                     // full turn, longest dy
		put_pair(-524288, 524287, 524287, -524288);           // longest offset, south-east
		put_pair(524287, 524287, -524288, -524288);           // longest offset, south-west
		put_pair(-524288, -524288, 524287, 524287);           // longest offset, north-east
		put_pair(524287, -524288, -524288, 524287);           // longest offset, north-west
		put_pair(0, 0, 1, 0);                                 // smallest step east
		put_pair(0, 0, 0, -1);                                // smallest step south
		put_pair(0, 0, -1, -1);                               // smallest diagonal
		put_pair(0, 524287, 1, -524288);                      // just east of south
		put_pair(0, 524287, -1, -524288);                     // just west of south
		put_pair(20'sh55555, 20'shAAAAA, 20'shAAAAA, 20'sh55555); // alternating bits
		put_pair(-1, -1, 0, 0);
		n_directed = 22;
		n_sent = n_directed;

		// random part
		while (n_sent < ITEMS_TOTAL) begin
			if (n_sent % 100 == 0) send_rate = $urandom_range(0, 4);
			if (n_sent == CALM_AT) calm = 1'b1;
			if (n_sent == HOLD_AT) hold_req = 1'b1;
			if (n_sent == DRAIN_AT) begin
				// stop offering until every result is back
				pos_ch.valid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			case ($urandom_range(0, 99)) inside
				[0:49]: begin
					// anywhere to anywhere
					rx = COORD_W'($urandom);
					ry = COORD_W'($urandom);
					tx = COORD_W'($urandom);
					ty = COORD_W'($urandom);
				end
				[50:69]: begin
					// target close to the robot, offsets of random size
					width = $urandom_range(1, 17);
					rx = COORD_W'($signed($urandom) >>> 14);
					ry = COORD_W'($signed($urandom) >>> 14);
					ox = longint'($signed($urandom) >>> (32 - width));
					oy = longint'($signed($urandom) >>> (32 - width));
					tx = COORD_W'(rx + ox);
					ty = COORD_W'(ry + oy);
				end
				[70:79]: begin
					// on an axis through the robot
					rx = COORD_W'($urandom);
					ry = COORD_W'($urandom);
					tx = COORD_W'($urandom);
					ty = COORD_W'($urandom);
					if ($urandom_range(0, 1)) tx = rx;
					else ty = ry;
				end
				[80:89]: begin
					// exact diagonals, 45 degree boundaries
					rx = COORD_W'($signed($urandom) >>> 14);
					ry = COORD_W'($signed($urandom) >>> 14);
					mag = longint'($urandom_range(1, 1 << 17));
					tx = $urandom_range(0, 1) ? COORD_W'(rx + mag) : COORD_W'(rx - mag);
					ty = $urandom_range(0, 1) ? COORD_W'(ry + mag) : COORD_W'(ry - mag);
				end
				[90:94]: begin
					// coincident positions
					rx = COORD_W'($urandom);
					ry = COORD_W'($urandom);
					tx = rx;
					ty = ry;
				end
				default: begin
					rx = corner_coord();
					ry = corner_coord();
					tx = corner_coord();
					ty = corner_coord();
				end
			endcase
			put_pair(rx, ry, tx, ty);
			n_sent++;
		end

		// all pairs taken: let the pipeline drain, then a little longer
		pos_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (2 * LATENCY + 10) @(posedge clk);

		$display("covered %0d position pairs (%0d directed), %0d results checked",
			pairs_seen, n_directed, fixes_seen);
		$display("with random gaps on both sides, a %0d-cycle result hold-off and a full drain",
			HOLD_CYCLES);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d bad results", fails);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/trb_pkg.sv
rtl/core/trb_pos_if.sv
rtl/core/trb_res_if.sv
rtl/core/trb_prerot.sv
rtl/core/trb_cell.sv
rtl/core/trb_post.sv
rtl/core/target_range_and_bearing.sv
dv/trb_range_checker.sv
dv/tb.sv
